// ===== src/ifr_pkg.sv =====
// ============================================================================
// ifr_pkg - shared types and constants of the info frame receiver
// Receiver phase codes, response kinds, register indexes and reset values.
// ============================================================================
package ifr_pkg;

    // receiver phase
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    // response to send back
    typedef enum logic [1:0] {
        RESP_NONE   = 2'd0,
        RESP_READY  = 2'd1,
        RESP_REJECT = 2'd2
    } t_resp;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned BYTE_W    = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_FLAG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL0    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL1    = 3'd6;

    // register reset values
    localparam t_byte RST_FLAG     = 8'h7E;
    localparam t_byte RST_ESC      = 8'h7D;
    localparam t_byte RST_ESC_FLAG = 8'h5E;
    localparam t_byte RST_ESC_ESC  = 8'h5D;
    localparam t_byte RST_ADDR     = 8'h03;
    localparam t_byte RST_CTRL0    = 8'h00;
    localparam t_byte RST_CTRL1    = 8'h40;

    // result sideband bit positions in tuser
    localparam int unsigned USER_W     = 5;
    localparam int unsigned U_DVALID   = 0;
    localparam int unsigned U_GOOD     = 1;
    localparam int unsigned U_KIND_LO  = 2;
    localparam int unsigned U_SEQ      = 4;

endpackage

// ===== src/info_frame_receiver.sv =====
// ============================================================================
// info_frame_receiver - byte-stuffed information frame receiver, XOR check
// Hunts for the flag, checks address/control/header XOR, un-escapes payload
// and checks the trailing XOR byte; answers with ready or reject.
// ============================================================================
// Usage: feed one raw line byte per slave request; every accepted byte gives
// exactly one master request in the next cycle, so without stalls it sustains
// one byte per clock. The frame state (phase, escape, held byte, running XOR,
// expected sequence bit) is the input side register set; one pass of compares
// and an XOR computes the result into the output register, which holds while
// the master side stalls so the next byte can still enter in the same cycle
// the stalled result is taken. Payload bytes come out delayed by one un-escaped
// byte: the byte before the closing flag is the check byte and is never
// emitted. Bytes of a bad frame already sent are not withdrawn; drop them on
// a frame end with frame_good low. Write the code registers only while idle.
module info_frame_receiver
    import ifr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // received line bytes
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,   // [7:0] rx_byte
    // results
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [BYTE_W-1:0]    o_m_tdata,   // [7:0] data_byte
    output logic                 o_m_tlast,   // frame_end
    output logic [USER_W-1:0]    o_m_tuser    // [0] data_valid, [1] frame_good,
                                              // [3:2] response_kind,
                                              // [4] response_seq
);

    // ---------------------------------------------------------------- config
    t_byte r_flag, r_esc, r_esc_flag, r_esc_esc, r_addr, r_ctrl0, r_ctrl1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag     <= RST_FLAG;
            r_esc      <= RST_ESC;
            r_esc_flag <= RST_ESC_FLAG;
            r_esc_esc  <= RST_ESC_ESC;
            r_addr     <= RST_ADDR;
            r_ctrl0    <= RST_CTRL0;
            r_ctrl1    <= RST_CTRL1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLAG:     r_flag     <= i_cfg_data;
                CFG_ESC:      r_esc      <= i_cfg_data;
                CFG_ESC_FLAG: r_esc_flag <= i_cfg_data;
                CFG_ESC_ESC:  r_esc_esc  <= i_cfg_data;
                CFG_ADDR:     r_addr     <= i_cfg_data;
                CFG_CTRL0:    r_ctrl0    <= i_cfg_data;
                CFG_CTRL1:    r_ctrl1    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ----------------------------------------------------------- frame state
    t_phase r_phase, n_phase;
    t_byte  r_ctrl_seen, n_ctrl_seen;
    logic   r_esc_pend, n_esc_pend;
    t_byte  r_held, n_held;
    logic   r_held_valid, n_held_valid;
    t_byte  r_xor, n_xor;
    logic   r_exp_seq, n_exp_seq;

    // result of the current byte
    logic   n_dvalid;
    t_byte  n_dbyte;
    logic   n_fend;
    logic   n_fgood;
    t_resp  n_kind;
    logic   n_seq;

    logic   s_acc;
    logic   have;
    t_byte  nb;
    t_byte  b;

    // output register frees up when taken, so a byte can enter every cycle unless stalled
    assign o_s_tready = !o_m_tvalid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign b          = i_s_tdata;

    always_comb begin
        n_phase      = r_phase;
        n_ctrl_seen  = r_ctrl_seen;
        n_esc_pend   = r_esc_pend;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_xor        = r_xor;
        n_exp_seq    = r_exp_seq;
        n_dvalid     = 1'b0;
        n_dbyte      = '0;
        n_fend       = 1'b0;
        n_fgood      = 1'b0;
        n_kind       = RESP_NONE;
        have         = 1'b0;
        nb           = '0;

        case (r_phase)
            PH_FLAG: begin
                if (b == r_addr)      n_phase = PH_ADDR;
                else if (b != r_flag) n_phase = PH_HUNT;
            end
            PH_ADDR: begin
                if (b == r_ctrl0 || b == r_ctrl1) begin
                    n_ctrl_seen = b;
                    n_phase     = PH_CTRL;
                end else if (b == r_flag) begin
                    n_phase = PH_FLAG;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CTRL: begin
                if (b == (r_addr ^ r_ctrl_seen)) begin
                    n_esc_pend   = 1'b0;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    n_xor        = '0;
                    n_phase      = PH_DATA;
                end else begin
                    n_kind  = RESP_REJECT;
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (b == r_esc) begin
                    n_esc_pend = 1'b1;
                end else if (b == r_flag) begin
                    // closing flag: held byte is the check byte
                    n_fend    = 1'b1;
                    n_fgood   = r_held_valid && (r_held == r_xor);
                    n_kind    = n_fgood ? RESP_READY : RESP_REJECT;
                    n_phase   = PH_HUNT;
                    n_exp_seq = r_exp_seq ^ n_fgood;
                    n_esc_pend   = 1'b0;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    n_xor        = '0;
                end else if (r_esc_pend) begin
                    // unknown escaped byte drops both
                    if (b == r_esc_flag) begin
                        nb   = r_flag;
                        have = 1'b1;
                    end else if (b == r_esc_esc) begin
                        nb   = r_esc;
                        have = 1'b1;
                    end
                    n_esc_pend = 1'b0;
                end else begin
                    nb   = b;
                    have = 1'b1;
                end
                if (have) begin
                    if (r_held_valid) begin
                        n_dvalid = 1'b1;
                        n_dbyte  = r_held;
                        n_xor    = r_xor ^ r_held;
                    end
                    n_held       = nb;
                    n_held_valid = 1'b1;
                end
            end
            default: begin
                n_phase = (b == r_flag) ? PH_FLAG : PH_HUNT;
            end
        endcase

        n_seq = (n_kind != RESP_NONE) ? ~r_exp_seq : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_ctrl_seen  <= '0;
            r_esc_pend   <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_xor        <= '0;
            r_exp_seq    <= 1'b0;
        end else if (s_acc) begin
            r_phase      <= n_phase;
            r_ctrl_seen  <= n_ctrl_seen;
            r_esc_pend   <= n_esc_pend;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_xor        <= n_xor;
            r_exp_seq    <= n_exp_seq;
        end
    end

    // --------------------------------------------------------- output stage
    logic  r_out_valid;
    logic  r_dvalid;
    t_byte r_dbyte;
    logic  r_fend;
    logic  r_fgood;
    t_resp r_kind;
    logic  r_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_dvalid <= n_dvalid;
            r_dbyte  <= n_dbyte;
            r_fend   <= n_fend;
            r_fgood  <= n_fgood;
            r_kind   <= n_kind;
            r_seq    <= n_seq;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_dbyte;
    assign o_m_tlast  = r_fend;
    assign o_m_tuser  = {r_seq, r_kind, r_fgood, r_dvalid};

`ifndef SYNTH
    // a frame end always carries a response
    a_end_has_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fend) |-> (r_kind != RESP_NONE))
        else $error("frame end without response");

    // good only with a frame end
    a_good_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fgood) |-> r_fend)
        else $error("frame_good without frame_end");

    // no response means no sequence bit
    a_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == RESP_NONE) |-> !r_seq)
        else $error("response_seq set without response");

    // running XOR only moves once a byte is held
    a_xor_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_valid |-> (r_xor == '0))
        else $error("running XOR nonzero with nothing held");

    // a good frame toggles the expected sequence bit
    a_seq_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && n_fend && n_fgood) |=> (r_exp_seq != $past(r_exp_seq)))
        else $error("expected sequence not toggled after good frame");
`endif

endmodule

// ===== bench/info_frame_receiver_chk.sv =====
`timescale 1ns / 100ps
// ============================================================================
// info_frame_receiver_chk - result checker for the info frame receiver
// Follows code register writes and both streams, predicts the result of
// every accepted line byte and compares it field by field on the way out.
// ============================================================================
module info_frame_receiver_chk
    import ifr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,   // [7:0] rx_byte
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [BYTE_W-1:0]    i_m_tdata,   // [7:0] data_byte
    input  logic                 i_m_tlast,   // frame_end
    input  logic [USER_W-1:0]    i_m_tuser,   // [0] data_valid, [1] frame_good,
                                              // [3:2] response_kind, [4] response_seq
    output int                   o_errors,
    output int                   o_outstanding
);

    typedef struct packed {
        logic  dvalid;
        t_byte dbyte;
        logic  fend;
        logic  fgood;
        t_resp kind;
        logic  seq;
    } t_rx_result;

    // code registers as the block should hold them
    t_byte flag_c, esc_c, esc_flag_c, esc_esc_c, addr_c, ctrl0_c, ctrl1_c;

    // frame state
    t_phase phase;
    t_byte  ctrl_seen;
    logic   esc_pend;
    t_byte  held;
    logic   held_ok;
    t_byte  run_xor;
    logic   exp_seq;

    t_rx_result pending_results[$];
    t_rx_result want;

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_errors < 100) begin
            $display("chk: %0t ns: %s", $time, msg);
        end
        o_errors++;
    endtask

    function automatic void drop_payload();
        esc_pend = 1'b0;
        held     = '0;
        held_ok  = 1'b0;
        run_xor  = '0;
    endfunction

    // one line byte in, one result out; updates the frame state
    function automatic t_rx_result decode_rx_byte(input t_byte b);
        t_rx_result r;
        logic       have;
        t_byte      nb;
        r      = '0;
        r.kind = RESP_NONE;
        have   = 1'b0;
        nb     = '0;
        case (phase)
            PH_FLAG: begin
                if (b == addr_c) phase = PH_ADDR;
                else if (b != flag_c) phase = PH_HUNT;
            end
            PH_ADDR: begin
                // control match wins over flag when codes collide
                if (b == ctrl0_c || b == ctrl1_c) begin
                    ctrl_seen = b;
                    phase     = PH_CTRL;
                end else if (b == flag_c) begin
                    phase = PH_FLAG;
                end else begin
                    phase = PH_HUNT;
                end
            end
            PH_CTRL: begin
                if (b == (addr_c ^ ctrl_seen)) begin
                    drop_payload();
                    phase = PH_DATA;
                end else begin
                    r.kind = RESP_REJECT;
                    phase  = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (b == esc_c) begin
                    esc_pend = 1'b1;
                end else if (b == flag_c) begin
                    // the held byte is the check byte; none held means bad
                    r.fend  = 1'b1;
                    r.fgood = held_ok && (held == run_xor);
                    r.kind  = r.fgood ? RESP_READY : RESP_REJECT;
                    phase   = PH_HUNT;
                end else if (esc_pend) begin
                    if (b == esc_flag_c) begin
                        nb   = flag_c;
                        have = 1'b1;
                    end else if (b == esc_esc_c) begin
                        nb   = esc_c;
                        have = 1'b1;
                    end
                    esc_pend = 1'b0;
                end else begin
                    nb   = b;
                    have = 1'b1;
                end
                if (have) begin
                    if (held_ok) begin
                        r.dvalid = 1'b1;
                        r.dbyte  = held;
                        run_xor  = run_xor ^ held;
                    end
                    held    = nb;
                    held_ok = 1'b1;
                end
            end
            default: phase = (b == flag_c) ? PH_FLAG : PH_HUNT;
        endcase
        if (r.kind != RESP_NONE) r.seq = ~exp_seq;
        if (r.fend) begin
            if (r.fgood) exp_seq = ~exp_seq;
            drop_payload();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flag_c     = RST_FLAG;
            esc_c      = RST_ESC;
            esc_flag_c = RST_ESC_FLAG;
            esc_esc_c  = RST_ESC_ESC;
            addr_c     = RST_ADDR;
            ctrl0_c    = RST_CTRL0;
            ctrl1_c    = RST_CTRL1;
            phase      = PH_HUNT;
            ctrl_seen  = '0;
            exp_seq    = 1'b0;
            drop_payload();
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FLAG:     flag_c     = i_cfg_data;
                    CFG_ESC:      esc_c      = i_cfg_data;
                    CFG_ESC_FLAG: esc_flag_c = i_cfg_data;
                    CFG_ESC_ESC:  esc_esc_c  = i_cfg_data;
                    CFG_ADDR:     addr_c     = i_cfg_data;
                    CFG_CTRL0:    ctrl0_c    = i_cfg_data;
                    CFG_CTRL1:    ctrl1_c    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, tdata %0h",
                                              i_m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (i_m_tuser[U_DVALID] !== want.dvalid)
                        report_mismatch($sformatf("data_valid %0b, want %0b",
                                                  i_m_tuser[U_DVALID], want.dvalid));
                    if (i_m_tdata !== want.dbyte)
                        report_mismatch($sformatf("data_byte %0h, want %0h",
                                                  i_m_tdata, want.dbyte));
                    if (i_m_tlast !== want.fend)
                        report_mismatch($sformatf("frame_end %0b, want %0b",
                                                  i_m_tlast, want.fend));
                    if (i_m_tuser[U_GOOD] !== want.fgood)
                        report_mismatch($sformatf("frame_good %0b, want %0b",
                                                  i_m_tuser[U_GOOD], want.fgood));
                    if (i_m_tuser[U_KIND_LO +: $bits(t_resp)] !== want.kind)
                        report_mismatch($sformatf("response_kind %0d, want %0d",
                                                  i_m_tuser[U_KIND_LO +: $bits(t_resp)],
                                                  want.kind));
                    if (i_m_tuser[U_SEQ] !== want.seq)
                        report_mismatch($sformatf("response_seq %0b, want %0b",
                                                  i_m_tuser[U_SEQ], want.seq));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_results.push_back(decode_rx_byte(i_s_tdata));
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

// ===== bench/info_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// info_frame_receiver_tb - stimulus and verdict for the info frame receiver
// Feeds directed corner bytes, then random framed traffic (good, bad check,
// bad header, wrong address, unknown escapes, cut frames, line noise) under
// several code register settings, with random gaps and back-pressure.
// ============================================================================
module info_frame_receiver_tb;
    import ifr_pkg::*;

    // shapes of the frames put on the line in the random part
    typedef enum int {
        FR_GOOD,
        FR_BAD_CHECK,
        FR_BAD_HEADER,
        FR_BAD_ADDR,
        FR_BAD_ESCAPE,
        FR_NO_CHECK,
        FR_NOISE
    } t_frame_shape;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    t_byte                cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    t_byte                s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    t_byte                m_tdata;
    logic                 m_tlast;
    logic [USER_W-1:0]    m_tuser;

    int errors;
    int outstanding;
    int sent = 0;        // line bytes accepted so far
    bit idle_en = 1'b1;  // random gaps on both streams

    // code values the line traffic is built from, indexed by register
    t_byte codes [0:6];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    info_frame_receiver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    info_frame_receiver_chk u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .i_m_tuser     (m_tuser),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // result side: stalls about one cycle in ten while idling is on
    always @(negedge clk) begin
        m_tready <= !idle_en || ($urandom_range(99) >= 10);
    end

    // one line byte request; entered and left at a falling edge, tvalid stays
    // high on return so back-to-back bytes need no extra assignment
    task automatic send_rx(input t_byte b);
        if (idle_en && $urandom_range(99) < 4) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        sent++;
    endtask

    // stop sending and wait until every result in flight has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // write all code registers; only called while the block is idle
    task automatic apply_codes();
        for (int i = 0; i <= int'(CFG_CTRL1); i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= codes[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // byte stuffing as a sender would do it
    function automatic void push_stuffed(ref t_byte q[$], input t_byte b);
        if (b == codes[CFG_FLAG]) begin
            q.push_back(codes[CFG_ESC]);
            q.push_back(codes[CFG_ESC_FLAG]);
        end else if (b == codes[CFG_ESC]) begin
            q.push_back(codes[CFG_ESC]);
            q.push_back(codes[CFG_ESC_ESC]);
        end else begin
            q.push_back(b);
        end
    endfunction

    task automatic send_frame(input t_frame_shape shape);
        t_byte raw[$];
        t_byte body[$];
        t_byte ctrl;
        t_byte bcc;
        int    len;
        int    hdr_end;
        int    pos;
        // mostly short payloads, now and then a longer one
        len  = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
        ctrl = $urandom_range(1) ? codes[CFG_CTRL1] : codes[CFG_CTRL0];
        bcc  = '0;
        // a quarter of the payload bytes are one of the flag/escape codes
        repeat (len) begin
            if ($urandom_range(3) == 0) body.push_back(codes[$urandom_range(int'(CFG_ESC_ESC))]);
            else body.push_back(t_byte'($urandom_range(255)));
        end
        foreach (body[i]) bcc ^= body[i];
        if (shape == FR_BAD_CHECK) bcc ^= t_byte'($urandom_range(255, 1));
        repeat ($urandom_range(2, 1)) raw.push_back(codes[CFG_FLAG]);
        case (shape)
            FR_NOISE: begin
                raw.delete();
                repeat ($urandom_range(8, 1)) raw.push_back(t_byte'($urandom_range(255)));
            end
            FR_BAD_ADDR: begin
                // random address, or the right one followed by a random control
                raw.push_back(t_byte'($urandom_range(255)));
                if ($urandom_range(1)) begin
                    raw.push_back(codes[CFG_ADDR]);
                    raw.push_back(t_byte'($urandom_range(255)));
                end
            end
            default: begin
                raw.push_back(codes[CFG_ADDR]);
                raw.push_back(ctrl);
                if (shape == FR_BAD_HEADER) begin
                    raw.push_back(codes[CFG_ADDR] ^ ctrl ^ t_byte'($urandom_range(255, 1)));
                end else begin
                    raw.push_back(codes[CFG_ADDR] ^ ctrl);
                    hdr_end = raw.size();
                    if (shape == FR_NO_CHECK) begin
                        // header straight into the closing flag, maybe past an escape
                        if ($urandom_range(1)) raw.push_back(codes[CFG_ESC]);
                    end else begin
                        foreach (body[i]) push_stuffed(raw, body[i]);
                        push_stuffed(raw, bcc);
                        if (shape == FR_BAD_ESCAPE) begin
                            pos = $urandom_range(raw.size(), hdr_end);
                            raw.insert(pos, codes[CFG_ESC]);
                            raw.insert(pos + 1, t_byte'($urandom_range(255)));
                        end
                    end
                    raw.push_back(codes[CFG_FLAG]);
                end
            end
        endcase
        foreach (raw[i]) send_rx(raw[i]);
    endtask

    // frames of random shape until about n more line bytes went in
    task automatic run_traffic(input int n);
        int           stop_at;
        int           r;
        t_frame_shape shape;
        stop_at = sent + n;
        while (sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 55)      shape = FR_GOOD;
            else if (r < 65) shape = FR_BAD_CHECK;
            else if (r < 73) shape = FR_BAD_HEADER;
            else if (r < 80) shape = FR_BAD_ADDR;
            else if (r < 88) shape = FR_BAD_ESCAPE;
            else if (r < 92) shape = FR_NO_CHECK;
            else             shape = FR_NOISE;
            send_frame(shape);
        end
    endtask

    initial begin
        t_byte opening[$];
        // order follows the register indexes
        codes = '{RST_FLAG, RST_ESC, RST_ESC_FLAG, RST_ESC_ESC,
                  RST_ADDR, RST_CTRL0, RST_CTRL1};
        opening = {
            // repeated flag before the address, flag while waiting for
            // control, then a header check mismatch
            RST_FLAG, RST_FLAG, RST_ADDR, RST_FLAG, RST_ADDR, RST_CTRL1,
            RST_ADDR ^ RST_CTRL1 ^ 8'h01,
            // header then closing flag: no check byte held
            RST_FLAG, RST_ADDR, RST_CTRL0, RST_ADDR ^ RST_CTRL0, RST_FLAG,
            // empty payload, check byte zero: good frame
            RST_FLAG, RST_ADDR, RST_CTRL1, RST_ADDR ^ RST_CTRL1, 8'h00, RST_FLAG,
            // wrong address, then wrong control
            RST_FLAG, 8'h05, RST_FLAG, RST_ADDR, 8'h22,
            // byte extremes, stuffed flag, escape twice, unknown escape,
            // flag while an escape is pending
            RST_FLAG, RST_ADDR, RST_CTRL0, RST_ADDR ^ RST_CTRL0, 8'hFF, 8'h00,
            RST_ESC, RST_ESC_FLAG, RST_ESC, RST_ESC, 8'h11, RST_ESC, RST_FLAG
        };
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        apply_codes();
        foreach (opening[i]) send_rx(opening[i]);
        run_traffic(120);
        // hold off the line until every result has been taken
        drain();
        run_traffic(120);
        drain();

        // extremes; both control codes equal to the flag
        codes = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h00};
        apply_codes();
        run_traffic(180);
        drain();

        // other extremes, run with no gaps and no stalls at all
        idle_en = 1'b0;
        codes = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01};
        apply_codes();
        run_traffic(180);
        drain();
        idle_en = 1'b1;

        foreach (codes[i]) codes[i] = t_byte'($urandom_range(255));
        apply_codes();
        run_traffic(100);
        drain();

        codes = '{RST_FLAG, RST_ESC, RST_ESC_FLAG, RST_ESC_ESC,
                  RST_ADDR, RST_CTRL0, RST_CTRL1};
        apply_codes();
        run_traffic(100);
        drain();

        // let any stray result show up before the verdict
        repeat (4) @(negedge clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
